/* design/mpi_pkg.sv */
// shared constants and types of the point morph interpolator
`timescale 1ns / 1ps

package mpi_pkg;

   // command carried in req_tuser
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_POINT   = 1'b1;

   // fixed field widths
   localparam int FRAME_BITS    = 8;
   localparam int COLOR_BITS    = 8;
   localparam int RGB_BITS      = 24;
   localparam int REG_BITS      = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int REQ_DATA_BITS = 112;
   localparam int RSP_DATA_BITS = 56;

   // request tdata layout, low bit of each field
   localparam int REQ_PAL_IDX_LSB = 0;
   localparam int REQ_PAL_RGB_LSB = 8;
   localparam int REQ_SX_LSB      = 32;
   localparam int REQ_SY_LSB      = 48;
   localparam int REQ_EX_LSB      = 64;
   localparam int REQ_EY_LSB      = 80;
   localparam int REQ_SC_LSB      = 96;
   localparam int REQ_EC_LSB      = 104;

   // interpolation lanes
   localparam int NUM_LANES = 5;
   localparam int LANE_X    = 0;
   localparam int LANE_Y    = 1;
   localparam int LANE_R    = 2;
   localparam int LANE_G    = 3;
   localparam int LANE_B    = 4;

   // quotient bits resolved per divider stage
   localparam int DIV_STEP = 3;

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_FRAME_COUNT = 3'd0,
      REG_FRAME_INDEX = 3'd1,
      REG_ORIGIN_X    = 3'd2,
      REG_ORIGIN_Y    = 3'd3,
      REG_CLIP_LEFT   = 3'd4,
      REG_CLIP_TOP    = 3'd5,
      REG_CLIP_RIGHT  = 3'd6,
      REG_CLIP_BOTTOM = 3'd7
   } csr_reg_type;

   // register reset values
   localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RST = 8'd8;
   localparam logic [FRAME_BITS-1:0] FRAME_INDEX_RST = 8'd0;
   localparam logic [REG_BITS-1:0]   CLIP_RIGHT_RST  = 16'd319;
   localparam logic [REG_BITS-1:0]   CLIP_BOTTOM_RST = 16'd199;

endpackage

/* design/morph_point_interpolator_unit.sv */
// Point morph interpolator: palette memory, lerp lanes, pipelined divider, clip test
//
// One request transaction is taken per clock while no response is stalled. A palette
// write updates the palette memory at the accepting edge and gives no response; a
// point reads both palette colours at the accepting edge and its response passes
// stage 1, stage 2, the divider, f1 and f2 on its way to the output register. The
// rate is set by the restoring divider, which resolves three quotient bits in each
// of its DIV_STAGES stages for all five lanes (x, y, red, green, blue) in parallel, so
// a new point enters every cycle unless a response is stalled. A stalled response
// freezes the whole pipeline and drops req_tready in the same cycle. Configuration is
// taken at any cycle but must only be changed while no point is in flight.
`timescale 1ns / 1ps

module morph_point_interpolator_unit #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int COORD_BITS      = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: palette_index, palette_rgb, start_x, start_y, end_x, end_y,
   // src_color, dst_color
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mpi_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                  req_tuser,   // cmd
   input  logic                                  req_tlast,   // frame_end_in
   // response: pixel_x, pixel_y, red, green, blue
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mpi_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,   // visible
   output logic                                  rsp_tlast,   // frame_end_out
   // configuration writes
   input  logic                                  csr_we,
   input  logic [mpi_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [mpi_pkg::REG_BITS-1:0]          csr_wdata
);

   localparam int PAL_IDX_BITS = $clog2(PALETTE_ENTRIES);
   localparam int MAG_BITS     = COORD_BITS + mpi_pkg::FRAME_BITS;
   localparam int DIV_STAGES   = (MAG_BITS + mpi_pkg::DIV_STEP - 1) / mpi_pkg::DIV_STEP;
   localparam int PAD_BITS     = DIV_STAGES * mpi_pkg::DIV_STEP;
   localparam int VAL_BITS     = MAG_BITS + 2;
   localparam int PX_BITS      = VAL_BITS + 1;
   localparam int FB           = mpi_pkg::FRAME_BITS;
   localparam int CB           = mpi_pkg::COLOR_BITS;
   localparam int RB           = mpi_pkg::REG_BITS;

   // one lane inside the divider
   typedef struct packed {
      logic                  neg;
      logic [COORD_BITS-1:0] base;
      logic [FB-1:0]         rem;
      logic [PAD_BITS-1:0]   work;
   } lane_type;

   // configuration registers
   logic        [FB-1:0] frame_count_ff;
   logic        [FB-1:0] frame_index_ff;
   logic signed [RB-1:0] origin_x_ff;
   logic signed [RB-1:0] origin_y_ff;
   logic signed [RB-1:0] clip_left_ff;
   logic signed [RB-1:0] clip_top_ff;
   logic signed [RB-1:0] clip_right_ff;
   logic signed [RB-1:0] clip_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= mpi_pkg::FRAME_COUNT_RST;
         frame_index_ff <= mpi_pkg::FRAME_INDEX_RST;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= mpi_pkg::CLIP_RIGHT_RST;
         clip_bottom_ff <= mpi_pkg::CLIP_BOTTOM_RST;
      end else if (csr_we) begin
         unique case (mpi_pkg::csr_reg_type'(csr_addr))
            mpi_pkg::REG_FRAME_COUNT: frame_count_ff <= csr_wdata[FB-1:0];
            mpi_pkg::REG_FRAME_INDEX: frame_index_ff <= csr_wdata[FB-1:0];
            mpi_pkg::REG_ORIGIN_X:    origin_x_ff    <= csr_wdata;
            mpi_pkg::REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
            mpi_pkg::REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            mpi_pkg::REG_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            mpi_pkg::REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            mpi_pkg::REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a zero frame count divides by one
   logic [FB-1:0] den;
   assign den = (frame_count_ff == '0) ? FB'(1) : frame_count_ff;

   // pipeline advance: the output register is free or being drained
   logic rsp_tvalid_ff;
   logic adv;
   logic req_accept;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   // request fields
   logic [7:0]                     in_pal_idx;
   logic [mpi_pkg::RGB_BITS-1:0]   in_pal_rgb;
   logic [7:0]                     in_sc;
   logic [7:0]                     in_ec;
   logic                           pal_we;
   assign in_pal_idx = req_tdata[mpi_pkg::REQ_PAL_IDX_LSB +: 8];
   assign in_pal_rgb = req_tdata[mpi_pkg::REQ_PAL_RGB_LSB +: mpi_pkg::RGB_BITS];
   assign in_sc      = req_tdata[mpi_pkg::REQ_SC_LSB +: 8];
   assign in_ec      = req_tdata[mpi_pkg::REQ_EC_LSB +: 8];
   assign pal_we     = req_accept && (req_tuser == mpi_pkg::CMD_PALETTE)
                       && (9'(in_pal_idx) < 9'(PALETTE_ENTRIES));

   // palette memory, one write and two reads per cycle while the pipeline advances
   logic [mpi_pkg::RGB_BITS-1:0] pal_mem [PALETTE_ENTRIES];
   logic [mpi_pkg::RGB_BITS-1:0] rd0_ff;
   logic [mpi_pkg::RGB_BITS-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[in_pal_idx[PAL_IDX_BITS-1:0]] <= in_pal_rgb;
      end
      if (adv) begin
         rd0_ff <= pal_mem[in_sc[PAL_IDX_BITS-1:0]];
         rd1_ff <= pal_mem[in_ec[PAL_IDX_BITS-1:0]];
      end
   end

   // stage 1: captured point fields
   logic                  s1_vld_ff;
   logic                  s1_fe_ff;
   logic                  s1_oor0_ff;
   logic                  s1_oor1_ff;
   logic [COORD_BITS-1:0] s1_sx_ff;
   logic [COORD_BITS-1:0] s1_sy_ff;
   logic [COORD_BITS-1:0] s1_ex_ff;
   logic [COORD_BITS-1:0] s1_ey_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_fe_ff   <= req_tlast;
         s1_oor0_ff <= !(9'(in_sc) < 9'(PALETTE_ENTRIES));
         s1_oor1_ff <= !(9'(in_ec) < 9'(PALETTE_ENTRIES));
         s1_sx_ff   <= req_tdata[mpi_pkg::REQ_SX_LSB +: COORD_BITS];
         s1_sy_ff   <= req_tdata[mpi_pkg::REQ_SY_LSB +: COORD_BITS];
         s1_ex_ff   <= req_tdata[mpi_pkg::REQ_EX_LSB +: COORD_BITS];
         s1_ey_ff   <= req_tdata[mpi_pkg::REQ_EY_LSB +: COORD_BITS];
      end
   end

   // stage 1 logic: lane operands, sign and magnitude of the difference
   logic [mpi_pkg::RGB_BITS-1:0] c0;
   logic [mpi_pkg::RGB_BITS-1:0] c1;
   logic [COORD_BITS-1:0]        s1_a   [mpi_pkg::NUM_LANES];
   logic [COORD_BITS-1:0]        s1_b   [mpi_pkg::NUM_LANES];
   logic                         s1_neg [mpi_pkg::NUM_LANES];
   logic [COORD_BITS-1:0]        s1_ad  [mpi_pkg::NUM_LANES];

   always_comb begin
      c0 = s1_oor0_ff ? '0 : rd0_ff;
      c1 = s1_oor1_ff ? '0 : rd1_ff;
      s1_a[mpi_pkg::LANE_X] = s1_sx_ff;
      s1_b[mpi_pkg::LANE_X] = s1_ex_ff;
      s1_a[mpi_pkg::LANE_Y] = s1_sy_ff;
      s1_b[mpi_pkg::LANE_Y] = s1_ey_ff;
      s1_a[mpi_pkg::LANE_R] = COORD_BITS'(c0[23:16]);
      s1_b[mpi_pkg::LANE_R] = COORD_BITS'(c1[23:16]);
      s1_a[mpi_pkg::LANE_G] = COORD_BITS'(c0[15:8]);
      s1_b[mpi_pkg::LANE_G] = COORD_BITS'(c1[15:8]);
      s1_a[mpi_pkg::LANE_B] = COORD_BITS'(c0[7:0]);
      s1_b[mpi_pkg::LANE_B] = COORD_BITS'(c1[7:0]);
      for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
         s1_neg[l] = s1_b[l] < s1_a[l];
         s1_ad[l]  = s1_neg[l] ? (s1_a[l] - s1_b[l]) : (s1_b[l] - s1_a[l]);
      end
   end

   // stage 2: magnitude, sign and base per lane
   logic                  s2_vld_ff;
   logic                  s2_fe_ff;
   logic                  s2_neg_ff  [mpi_pkg::NUM_LANES];
   logic [COORD_BITS-1:0] s2_ad_ff   [mpi_pkg::NUM_LANES];
   logic [COORD_BITS-1:0] s2_base_ff [mpi_pkg::NUM_LANES];

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_fe_ff <= s1_fe_ff;
         for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
            s2_neg_ff[l]  <= s1_neg[l];
            s2_ad_ff[l]   <= s1_ad[l];
            s2_base_ff[l] <= s1_a[l];
         end
      end
   end

   // three restoring division steps on one lane
   function automatic lane_type div_step(lane_type cur, logic [FB-1:0] d);
      lane_type    nxt;
      logic [FB:0] r;
      nxt = cur;
      for (int i = 0; i < mpi_pkg::DIV_STEP; i++) begin
         r        = {nxt.rem, nxt.work[PAD_BITS-1]};
         nxt.work = {nxt.work[PAD_BITS-2:0], 1'b0};
         if (r >= {1'b0, d}) begin
            r           = r - {1'b0, d};
            nxt.work[0] = 1'b1;
         end
         nxt.rem = r[FB-1:0];
      end
      return nxt;
   endfunction

   // divider pipeline; entry 0 takes the product, the last entry holds quotients
   lane_type dv_ff     [DIV_STAGES+1][mpi_pkg::NUM_LANES];
   logic     dv_vld_ff [DIV_STAGES+1];
   logic     dv_fe_ff  [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_fe_ff[0] <= s2_fe_ff;
         for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
            dv_ff[0][l].neg  <= s2_neg_ff[l];
            dv_ff[0][l].base <= s2_base_ff[l];
            dv_ff[0][l].rem  <= '0;
            dv_ff[0][l].work <= PAD_BITS'(MAG_BITS'(s2_ad_ff[l]) * MAG_BITS'(frame_index_ff));
         end
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_fe_ff[s+1] <= dv_fe_ff[s];
            for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
               dv_ff[s+1][l] <= div_step(dv_ff[s][l], den);
            end
         end
      end
   end

   // f1: signed quotient plus start value
   logic                       f1_vld_ff;
   logic                       f1_fe_ff;
   logic signed [VAL_BITS-1:0] f1_val_ff [mpi_pkg::NUM_LANES];
   logic signed [VAL_BITS-1:0] f1_q      [mpi_pkg::NUM_LANES];
   logic signed [VAL_BITS-1:0] f1_base   [mpi_pkg::NUM_LANES];

   always_comb begin
      for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
         f1_q[l]    = VAL_BITS'(dv_ff[DIV_STAGES][l].work);
         f1_base[l] = VAL_BITS'(dv_ff[DIV_STAGES][l].base);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_fe_ff <= dv_fe_ff[DIV_STAGES];
         for (int l = 0; l < mpi_pkg::NUM_LANES; l++) begin
            f1_val_ff[l] <= dv_ff[DIV_STAGES][l].neg ? (f1_base[l] - f1_q[l])
                                                     : (f1_base[l] + f1_q[l]);
         end
      end
   end

   // f2: origin offset at full precision
   logic                      f2_vld_ff;
   logic                      f2_fe_ff;
   logic signed [PX_BITS-1:0] f2_px_ff;
   logic signed [PX_BITS-1:0] f2_py_ff;
   logic [CB-1:0]             f2_r_ff;
   logic [CB-1:0]             f2_g_ff;
   logic [CB-1:0]             f2_b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_fe_ff <= f1_fe_ff;
         f2_px_ff <= PX_BITS'(f1_val_ff[mpi_pkg::LANE_X]) + PX_BITS'(origin_x_ff);
         f2_py_ff <= PX_BITS'(f1_val_ff[mpi_pkg::LANE_Y]) + PX_BITS'(origin_y_ff);
         f2_r_ff  <= f1_val_ff[mpi_pkg::LANE_R][CB-1:0];
         f2_g_ff  <= f1_val_ff[mpi_pkg::LANE_G][CB-1:0];
         f2_b_ff  <= f1_val_ff[mpi_pkg::LANE_B][CB-1:0];
      end
   end

   // clip box test
   logic vis;
   assign vis = (f2_px_ff >= PX_BITS'(clip_left_ff)) && (f2_px_ff <= PX_BITS'(clip_right_ff))
             && (f2_py_ff >= PX_BITS'(clip_top_ff))  && (f2_py_ff <= PX_BITS'(clip_bottom_ff));

   // output register
   logic [mpi_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                              rsp_vis_ff;
   logic                              rsp_fe_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {f2_b_ff, f2_g_ff, f2_r_ff, f2_py_ff[RB-1:0], f2_px_ff[RB-1:0]};
         rsp_vis_ff  <= vis;
         rsp_fe_ff   <= f2_fe_ff;
      end
   end

   // valid flags of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         f1_vld_ff     <= 1'b0;
         f2_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int s = 0; s <= DIV_STAGES; s++) begin
            dv_vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff    <= req_accept && (req_tuser == mpi_pkg::CMD_POINT);
         s2_vld_ff    <= s1_vld_ff;
         dv_vld_ff[0] <= s2_vld_ff;
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
         f1_vld_ff     <= dv_vld_ff[DIV_STAGES];
         f2_vld_ff     <= f1_vld_ff;
         rsp_tvalid_ff <= f2_vld_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_vis_ff;
   assign rsp_tlast  = rsp_fe_ff;

endmodule

/* design/mpi_checker.sv */
// port-level checks of the point morph interpolator and their bind
`timescale 1ns / 1ps

module mpi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mpi_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                   && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // request side is blocked only by a stalled response
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow the output stall");

   // no response right out of reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // handshake outputs are always known once out of reset
   a_known_flow: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_tvalid, req_tready}))
      else $error("unknown value on a handshake output");

endmodule

bind morph_point_interpolator_unit mpi_checker u_mpi_checker (.*);
